[src/easter_sunday_serial_unit_macros.svh]
// Assertion helpers for the RTL file that checks itself.
// Each macro expects clk and rst_n in scope.
`ifndef EASTER_SUNDAY_SERIAL_UNIT_MACROS_SVH
`define EASTER_SUNDAY_SERIAL_UNIT_MACROS_SVH

// Same-cycle implication.
`define ESSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ESSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/essu_pkg.sv]
`timescale 1ns / 1ps

package essu_pkg;

  localparam int YEAR_W     = 16;
  localparam int NY_W       = 14;
  localparam int NM_W       = 4;
  localparam int ND_W       = 5;
  localparam int MON_W      = 3;
  localparam int DAY_W      = 5;
  localparam int SERIAL_W   = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic signed [YEAR_W-1:0] FIRST_YEAR = 16'sd1583;
  localparam logic signed [YEAR_W-1:0] LAST_YEAR  = 16'sd9956;

  localparam logic [NY_W-1:0] NULL_YEAR_RST  = 14'd1899;
  localparam logic [NM_W-1:0] NULL_MONTH_RST = 4'd12;
  localparam logic [ND_W-1:0] NULL_DAY_RST   = 5'd30;

  localparam logic [MON_W-1:0] MON_NONE  = 3'd0;
  localparam logic [MON_W-1:0] MON_MARCH = 3'd3;
  localparam logic [MON_W-1:0] MON_APRIL = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NULL_YEAR  = 2'd0,
    REG_NULL_MONTH = 2'd1,
    REG_NULL_DAY   = 2'd2
  } cfg_reg_t;

  // Reference date, month already saturated to 1..12.
  typedef struct packed {
    logic [NY_W-1:0] year;
    logic [NM_W-1:0] month;
    logic [ND_W-1:0] day;
  } null_date_t;

  // Days before the first of a month, counted in a year that starts in March.
  function automatic logic [8:0] month_offset(input logic [NM_W-1:0] mon);
    logic [8:0] ofs;
    begin
      case (mon)
        4'd3:    ofs = 9'd0;
        4'd4:    ofs = 9'd31;
        4'd5:    ofs = 9'd61;
        4'd6:    ofs = 9'd92;
        4'd7:    ofs = 9'd122;
        4'd8:    ofs = 9'd153;
        4'd9:    ofs = 9'd184;
        4'd10:   ofs = 9'd214;
        4'd11:   ofs = 9'd245;
        4'd12:   ofs = 9'd275;
        4'd1:    ofs = 9'd306;
        4'd2:    ofs = 9'd337;
        default: ofs = 9'd0;
      endcase
      return ofs;
    end
  endfunction

  // Floor of x / 100 by reciprocal multiply, exact for x below 25600.
  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [27:0] prod;
    begin
      prod = {13'd0, x} * 28'd5243;
      return prod[26:19];
    end
  endfunction

  // Day count of March 1st of year yy: yy*365 + yy/4 - yy/100 + yy/400.
  function automatic logic [22:0] year_days(input logic [14:0] yy,
                                            input logic [7:0]  cent);
    logic [22:0] acc;
    begin
      acc = {8'd0, yy} * 23'd365 + {10'd0, yy[14:2]} - {15'd0, cent}
          + {17'd0, cent[7:2]};
      return acc;
    end
  endfunction

endpackage

[src/essu_if.sv]
`timescale 1ns / 1ps

interface essu_in_if;
  import essu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [YEAR_W-1:0] year;
  modport source (output valid, output year, input ready);
  modport sink   (input valid, input year, output ready);
endinterface

interface essu_out_if;
  import essu_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       valid_res;
  logic [MON_W-1:0]           easter_month;
  logic [DAY_W-1:0]           easter_day;
  logic signed [SERIAL_W-1:0] serial;
  modport source (output valid, output valid_res, output easter_month,
                  output easter_day, output serial, input ready);
  modport sink   (input valid, input valid_res, input easter_month,
                  input easter_day, input serial, output ready);
endinterface

interface essu_cfg_if;
  import essu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/essu_cfg.sv]
`timescale 1ns / 1ps

module essu_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  essu_cfg_if.sink             cfg_ch,
  output essu_pkg::null_date_t null_date
);
  import essu_pkg::*;

  logic [NY_W-1:0] ny_r;
  logic [NM_W-1:0] nm_r;
  logic [ND_W-1:0] nd_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ny_r <= NULL_YEAR_RST;
      nm_r <= NULL_MONTH_RST;
      nd_r <= NULL_DAY_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_NULL_YEAR:  ny_r <= cfg_ch.data[NY_W-1:0];
        REG_NULL_MONTH: nm_r <= cfg_ch.data[NM_W-1:0];
        REG_NULL_DAY:   nd_r <= cfg_ch.data[ND_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate month into 1..12; day passes as a linear offset.
  always_comb begin
    null_date.year  = ny_r;
    null_date.day   = nd_r;
    if (nm_r == 4'd0) begin
      null_date.month = 4'd1;
    end else if (nm_r > 4'd12) begin
      null_date.month = 4'd12;
    end else begin
      null_date.month = nm_r;
    end
  end

endmodule

[src/easter_sunday_serial_unit.sv]
`timescale 1ns / 1ps

// Channel  | Dir | Handshake    | Payload
// ---------+-----+--------------+-------------------------------------------------
// in_ch    | in  | valid/ready  | year (16b signed)
// out_ch   | out | valid/ready  | valid_res, easter_month, easter_day, serial (23b)
// cfg_ch   | in  | valid/ready  | index (0 year, 1 month, 2 day), data (14b)
//
// Eight register stages, with out_ch.valid taken from the last; one item can enter
// every cycle while out_ch.ready is high. Divides by 19, 100, 25, 3, 30 and 7 use
// reciprocal multiplies, those by 451 and 31 a compare; no stage chains two of them.
// rst_n is synchronous; it clears the valid bits and loads the null date 1899-12-30.
// cfg_ch is always ready. A stage holds its item only while the next one is full and
// stalled, so bubbles collapse and in_ch stays ready while any stage is free.

module easter_sunday_serial_unit (
  input  logic       clk,
  input  logic       rst_n,
  essu_in_if.sink    in_ch,
  essu_out_if.source out_ch,
  essu_cfg_if.sink   cfg_ch
);
  import essu_pkg::*;

  `include "easter_sunday_serial_unit_macros.svh"

  localparam int NUM_ST = 8;

  null_date_t nd;

  essu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ch    (cfg_ch),
    .null_date (nd)
  );

  // ---------------------------------------------------------------------------
  // Pipeline control: stage k advances when it is empty or stage k+1 advances.
  // ---------------------------------------------------------------------------
  logic [NUM_ST:1] vld_r;
  logic [NUM_ST:1] vld_nxt;
  logic [NUM_ST:1] en;

  always_comb begin
    en[NUM_ST] = !vld_r[NUM_ST] || out_ch.ready;
    for (int k = NUM_ST - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[1] = en[1] ? in_ch.valid : vld_r[1];
    for (int k = 2; k <= NUM_ST; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready = en[1];

  // ---------------------------------------------------------------------------
  // Stage 1: range check, century and golden-number quotients, year offsets.
  // ---------------------------------------------------------------------------
  logic              ok1_nxt, ok1_r;
  logic [13:0]       y1_nxt, y1_r;
  logic [6:0]        cent1_nxt, cent1_r;
  logic [9:0]        q19_1_nxt, q19_1_r;
  logic [14:0]       eyy1_nxt, eyy1_r;
  logic [14:0]       nyy1_nxt, nyy1_r;
  logic signed [9:0] ndoy1_nxt, ndoy1_r;

  always_comb begin
    logic [7:0]  c8;
    logic [27:0] p19;
    ok1_nxt   = (in_ch.year >= FIRST_YEAR) && (in_ch.year <= LAST_YEAR);
    y1_nxt    = in_ch.year[13:0];
    c8        = div100({1'b0, y1_nxt});
    cent1_nxt = c8[6:0];
    p19       = {14'd0, y1_nxt} * 28'd13798;
    q19_1_nxt = p19[27:18];
    // Easter falls in March or April, so its year never shifts back.
    eyy1_nxt  = {1'b0, y1_nxt} + 15'd400;
    nyy1_nxt  = {1'b0, nd.year} + 15'd400 - {14'd0, (nd.month <= 4'd2)};
    ndoy1_nxt = $signed({1'b0, month_offset(nd.month)}) + $signed({5'd0, nd.day})
              - 10'sd1;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: remainders, f = (cent + 8) / 25, centuries of both year counts.
  // ---------------------------------------------------------------------------
  logic              ok2_r;
  logic [4:0]        gold2_nxt, gold2_r;
  logic [6:0]        rem2_nxt, rem2_r;
  logic [6:0]        cent2_r;
  logic [2:0]        f2_nxt, f2_r;
  logic [7:0]        ec2_nxt, ec2_r;
  logic [7:0]        nc2_nxt, nc2_r;
  logic [14:0]       eyy2_r, nyy2_r;
  logic signed [9:0] ndoy2_r;

  always_comb begin
    logic [13:0] t19, t100;
    logic [7:0]  fx;
    logic [12:0] fp;
    t19       = y1_r - {4'd0, q19_1_r} * 14'd19;
    gold2_nxt = t19[4:0];
    t100      = y1_r - {7'd0, cent1_r} * 14'd100;
    rem2_nxt  = t100[6:0];
    fx        = {1'b0, cent1_r} + 8'd8;
    fp        = {5'd0, fx} * 13'd41;
    f2_nxt    = fp[12:10];
    ec2_nxt   = div100(eyy1_r);
    nc2_nxt   = div100(nyy1_r);
  end

  // ---------------------------------------------------------------------------
  // Stage 3: g = (cent - f + 1) / 3, digit splits, day counts of both years.
  // ---------------------------------------------------------------------------
  logic               ok3_r;
  logic [4:0]         gold3_r;
  logic [6:0]         cent3_r;
  logic [5:0]         g3_nxt, g3_r;
  logic [4:0]         cq4_3_nxt, cq4_3_r;
  logic [1:0]         cr4_3_nxt, cr4_3_r;
  logic [4:0]         rq4_3_nxt, rq4_3_r;
  logic [1:0]         rr4_3_nxt, rr4_3_r;
  logic [22:0]        eyd3_nxt, eyd3_r;
  logic signed [23:0] ndn3_nxt, ndn3_r;

  always_comb begin
    logic [7:0]  gx;
    logic [14:0] gp;
    gx        = {1'b0, cent2_r} - {5'd0, f2_r} + 8'd1;
    gp        = {7'd0, gx} * 15'd171;
    g3_nxt    = gp[14:9];
    cq4_3_nxt = cent2_r[6:2];
    cr4_3_nxt = cent2_r[1:0];
    rq4_3_nxt = rem2_r[6:2];
    rr4_3_nxt = rem2_r[1:0];
    eyd3_nxt  = year_days(eyy2_r, ec2_r);
    ndn3_nxt  = $signed({1'b0, year_days(nyy2_r, nc2_r)})
              + $signed({{14{ndoy2_r[9]}}, ndoy2_r});
  end

  // ---------------------------------------------------------------------------
  // Stage 4: epact sum before mod 30.
  // ---------------------------------------------------------------------------
  logic               ok4_r;
  logic [4:0]         gold4_r;
  logic [9:0]         hsum4_nxt, hsum4_r;
  logic [1:0]         cr4_4_r, rr4_4_r;
  logic [4:0]         rq4_4_r;
  logic [22:0]        eyd4_r;
  logic signed [23:0] ndn4_r;

  always_comb begin
    hsum4_nxt = {5'd0, gold3_r} * 10'd19 + {3'd0, cent3_r} - {5'd0, cq4_3_r}
              - {4'd0, g3_r} + 10'd15;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: h = hsum mod 30; fold the year day counts into one difference.
  // ---------------------------------------------------------------------------
  logic               ok5_r;
  logic [4:0]         gold5_r;
  logic [4:0]         h5_nxt, h5_r;
  logic [1:0]         cr4_5_r, rr4_5_r;
  logic [4:0]         rq4_5_r;
  logic signed [23:0] diff5_nxt, diff5_r;

  always_comb begin
    logic [17:0] hp;
    logic [9:0]  ht;
    hp        = {8'd0, hsum4_r} * 18'd547;
    ht        = hsum4_r - {6'd0, hp[17:14]} * 10'd30;
    h5_nxt    = ht[4:0];
    diff5_nxt = $signed({1'b0, eyd4_r}) - ndn4_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: l = (32 + 2e + 2i - h - k) mod 7.
  // ---------------------------------------------------------------------------
  logic               ok6_r;
  logic [4:0]         gold6_r;
  logic [4:0]         h6_r;
  logic [2:0]         l6_nxt, l6_r;
  logic signed [23:0] diff6_r;

  always_comb begin
    logic [6:0]  lx;
    logic [13:0] lp;
    logic [6:0]  lt;
    lx     = 7'd32 + {4'd0, cr4_5_r, 1'b0} + {1'b0, rq4_5_r, 1'b0} - {2'd0, h5_r}
           - {5'd0, rr4_5_r};
    lp     = {7'd0, lx} * 14'd147;
    lt     = lx - {3'd0, lp[13:10]} * 7'd7;
    l6_nxt = lt[2:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 7: correction m = (a + 11h + 22l) / 451 and the day offset o.
  // ---------------------------------------------------------------------------
  logic               ok7_r;
  logic [7:0]         o7_nxt, o7_r;
  logic signed [23:0] diff7_r;

  always_comb begin
    logic [8:0] msum;
    logic       corr;
    msum   = {4'd0, gold6_r} + {4'd0, h6_r} * 9'd11 + {6'd0, l6_r} * 9'd22;
    corr   = msum >= 9'd451;
    o7_nxt = {3'd0, h6_r} + {5'd0, l6_r} + 8'd114 - (corr ? 8'd7 : 8'd0);
  end

  // ---------------------------------------------------------------------------
  // Stage 8 (output register): month, day and serial; zero when out of range.
  // ---------------------------------------------------------------------------
  logic                       res8_nxt, res8_r;
  logic [MON_W-1:0]           mon8_nxt, mon8_r;
  logic [DAY_W-1:0]           day8_nxt, day8_r;
  logic signed [SERIAL_W-1:0] ser8_nxt, ser8_r;

  always_comb begin
    logic               apr;
    logic [7:0]         dt;
    logic signed [23:0] st;
    apr = o7_r >= 8'd124;
    dt  = apr ? (o7_r - 8'd123) : (o7_r - 8'd92);
    // Day of a March-based year is o - 93 for either month.
    st  = diff7_r + $signed({16'd0, o7_r}) - 24'sd93;
    res8_nxt = ok7_r;
    if (ok7_r) begin
      mon8_nxt = apr ? MON_APRIL : MON_MARCH;
      day8_nxt = dt[4:0];
      ser8_nxt = st[SERIAL_W-1:0];
    end else begin
      mon8_nxt = MON_NONE;
      day8_nxt = '0;
      ser8_nxt = '0;
    end
  end

  // Payload registers: load on stage advance, hold otherwise.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ok1_r   <= ok1_nxt;
      y1_r    <= y1_nxt;
      cent1_r <= cent1_nxt;
      q19_1_r <= q19_1_nxt;
      eyy1_r  <= eyy1_nxt;
      nyy1_r  <= nyy1_nxt;
      ndoy1_r <= ndoy1_nxt;
    end
    if (en[2]) begin
      ok2_r   <= ok1_r;
      gold2_r <= gold2_nxt;
      rem2_r  <= rem2_nxt;
      cent2_r <= cent1_r;
      f2_r    <= f2_nxt;
      ec2_r   <= ec2_nxt;
      nc2_r   <= nc2_nxt;
      eyy2_r  <= eyy1_r;
      nyy2_r  <= nyy1_r;
      ndoy2_r <= ndoy1_r;
    end
    if (en[3]) begin
      ok3_r   <= ok2_r;
      gold3_r <= gold2_r;
      cent3_r <= cent2_r;
      g3_r    <= g3_nxt;
      cq4_3_r <= cq4_3_nxt;
      cr4_3_r <= cr4_3_nxt;
      rq4_3_r <= rq4_3_nxt;
      rr4_3_r <= rr4_3_nxt;
      eyd3_r  <= eyd3_nxt;
      ndn3_r  <= ndn3_nxt;
    end
    if (en[4]) begin
      ok4_r   <= ok3_r;
      gold4_r <= gold3_r;
      hsum4_r <= hsum4_nxt;
      cr4_4_r <= cr4_3_r;
      rq4_4_r <= rq4_3_r;
      rr4_4_r <= rr4_3_r;
      eyd4_r  <= eyd3_r;
      ndn4_r  <= ndn3_r;
    end
    if (en[5]) begin
      ok5_r   <= ok4_r;
      gold5_r <= gold4_r;
      h5_r    <= h5_nxt;
      cr4_5_r <= cr4_4_r;
      rq4_5_r <= rq4_4_r;
      rr4_5_r <= rr4_4_r;
      diff5_r <= diff5_nxt;
    end
    if (en[6]) begin
      ok6_r   <= ok5_r;
      gold6_r <= gold5_r;
      h6_r    <= h5_r;
      l6_r    <= l6_nxt;
      diff6_r <= diff5_r;
    end
    if (en[7]) begin
      ok7_r   <= ok6_r;
      o7_r    <= o7_nxt;
      diff7_r <= diff6_r;
    end
    if (en[8]) begin
      res8_r <= res8_nxt;
      mon8_r <= mon8_nxt;
      day8_r <= day8_nxt;
      ser8_r <= ser8_nxt;
    end
  end

  assign out_ch.valid        = vld_r[NUM_ST];
  assign out_ch.valid_res    = res8_r;
  assign out_ch.easter_month = mon8_r;
  assign out_ch.easter_day   = day8_r;
  assign out_ch.serial       = ser8_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ESSU_ASSERT_IMP(a_invalid_zero, out_ch.valid && !out_ch.valid_res, (out_ch.easter_month == MON_NONE) && (out_ch.easter_day == '0) && (out_ch.serial == '0), "out-of-range year gave nonzero fields")
  `ESSU_ASSERT_IMP(a_easter_window, out_ch.valid && out_ch.valid_res, ((out_ch.easter_month == MON_MARCH) && (out_ch.easter_day >= 5'd22)) || ((out_ch.easter_month == MON_APRIL) && (out_ch.easter_day >= 5'd1) && (out_ch.easter_day <= 5'd25)), "Easter date outside March 22 to April 25")
  `ESSU_ASSERT_NXT(a_range_flag, in_ch.valid && in_ch.ready && (in_ch.year >= FIRST_YEAR) && (in_ch.year <= LAST_YEAR), vld_r[1] && ok1_r, "in-range year not flagged in stage 1")
  `ESSU_ASSERT_NXT(a_stall_hold, vld_r[NUM_ST-1] && !en[NUM_ST], vld_r[NUM_ST-1] && $stable(o7_r) && $stable(diff7_r), "stalled stage 7 lost its item")

endmodule

[test/easter_sunday_serial_unit_test.sv]
`timescale 1ns / 1ps

module easter_sunday_serial_unit_test;
  import essu_pkg::*;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Cycles without any handshake before the run is declared hung. A receiver
  // that stalls half of the time never gets anywhere near this.
  localparam int QUIET_LIMIT       = 2000;
  // Pipeline is 8 deep; give it a little more before the verdict.
  localparam int SETTLE_CYCLES     = 16;
  localparam int SEGMENTS          = 6;
  localparam int ITEMS_PER_SEGMENT = 192;

  typedef struct packed {
    logic                       ok;
    logic [MON_W-1:0]           month;
    logic [DAY_W-1:0]           day;
    logic signed [SERIAL_W-1:0] serial;
  } easter_t;

  // Out-of-range years give all zeros.
  localparam easter_t NO_EASTER = '0;

  // One row of the directed part: a register write or a year. A year row
  // either carries its answer or leaves it to the predictor.
  typedef struct {
    bit                       is_cfg;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    data;
    logic signed [YEAR_W-1:0] year;
    bit                       typed;
    easter_t                  want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  essu_in_if  in_ch ();
  essu_out_if out_ch ();
  essu_cfg_if cfg_ch ();

  easter_sunday_serial_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Our own copy of the reference date, tracked as writes are accepted.
  logic [NY_W-1:0] epoch_year  = NULL_YEAR_RST;
  logic [NM_W-1:0] epoch_month = NULL_MONTH_RST;
  logic [ND_W-1:0] epoch_day   = NULL_DAY_RST;

  easter_t   pending_easters[$];
  plan_row_t plan[$];
  int        mismatches   = 0;
  int        quiet_cycles = 0;
  int        src_idle_pct = 29;
  int        snk_idle_pct = 47;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Proleptic Gregorian day count with a fixed bias that cancels in any
  // difference. The year is shifted by 400 so that it never goes negative,
  // and the year is counted from March so that leap days fall at its end.
  // A day outside the month simply runs on linearly.
  function automatic longint day_count(input longint y, input longint m, input longint d);
    longint yy, cyc, yoc, mp, doy;
    yy  = y + 400 - ((m <= 2) ? 1 : 0);
    cyc = yy / 400;
    yoc = yy - cyc * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    return cyc * 146097 + yoc * 365 + yoc / 4 - yoc / 100 + doy;
  endfunction

  // Anonymous Gregorian computus, then the distance to the reference date.
  function automatic easter_t easter_of(input logic signed [YEAR_W-1:0] yr);
    easter_t res;
    int      y, golden, cent, yic, h, l, m, o, mon, dom;
    longint  month_sat, diff;
    res = NO_EASTER;
    y   = int'(yr);
    if (y < FIRST_YEAR || y > LAST_YEAR) begin
      return res;
    end
    golden = y % 19;
    cent   = y / 100;
    yic    = y % 100;
    // h: epact-like term; l: weekday correction to reach Sunday.
    h   = (19 * golden + cent - cent / 4 - (cent - (cent + 8) / 25 + 1) / 3 + 15) % 30;
    l   = (32 + 2 * (cent % 4) + 2 * (yic / 4) - h - yic % 4) % 7;
    m   = (golden + 11 * h + 22 * l) / 451;
    o   = h + l - 7 * m + 114;
    mon = o / 31;
    dom = o % 31 + 1;
    // Clamp the reference month into 1..12; day and year are used as given.
    month_sat = longint'(epoch_month);
    if (month_sat < 1) begin
      month_sat = 1;
    end
    if (month_sat > 12) begin
      month_sat = 12;
    end
    diff = day_count(longint'(y), longint'(mon), longint'(dom))
         - day_count(longint'(epoch_year), month_sat, longint'(epoch_day));
    res.ok     = 1'b1;
    res.month  = mon[MON_W-1:0];
    res.day    = dom[DAY_W-1:0];
    // Keep the low 23 bits only; far-off reference years wrap here.
    res.serial = diff[SERIAL_W-1:0];
    return res;
  endfunction

  // Offer one year; on acceptance queue what it must produce. Enter and
  // leave at a falling edge. Lower the config valid left from a prior write.
  task automatic send_year(input logic signed [YEAR_W-1:0] yr, input bit typed,
                           input easter_t want);
    cfg_ch.valid <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.year  <= YEAR_W'($urandom);
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.year  <= yr;
    do @(posedge clk); while (!in_ch.ready);
    pending_easters.push_back(typed ? want : easter_of(yr));
    @(negedge clk);
  endtask

  // Write one register once the pipeline has drained; leave valid high so
  // that a following write can go back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_ch.valid <= 1'b0;
    while (pending_easters.size() != 0) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_NULL_YEAR:  epoch_year  = data[NY_W-1:0];
      REG_NULL_MONTH: epoch_month = data[NM_W-1:0];
      REG_NULL_DAY:   epoch_day   = data[ND_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_epoch(input logic [CFG_DATA_W-1:0] y, input logic [CFG_DATA_W-1:0] m,
                           input logic [CFG_DATA_W-1:0] d);
    write_reg(REG_NULL_YEAR, y);
    write_reg(REG_NULL_MONTH, m);
    write_reg(REG_NULL_DAY, d);
  endtask

  // Receiver: drop ready at random, at the rate of the current phase.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    easter_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_easters.size() == 0) begin
        $error("unexpected result item: valid_res %0b month %0d day %0d serial %0d",
               out_ch.valid_res, out_ch.easter_month, out_ch.easter_day, out_ch.serial);
        mismatches++;
      end else begin
        want = pending_easters.pop_front();
        if (out_ch.valid_res !== want.ok) begin
          $error("valid_res: expected %0b, got %0b", want.ok, out_ch.valid_res);
          mismatches++;
        end
        if (out_ch.easter_month !== want.month) begin
          $error("easter_month: expected %0d, got %0d", want.month, out_ch.easter_month);
          mismatches++;
        end
        if (out_ch.easter_day !== want.day) begin
          $error("easter_day: expected %0d, got %0d", want.day, out_ch.easter_day);
          mismatches++;
        end
        if (out_ch.serial !== want.serial) begin
          $error("serial: expected %0d, got %0d", want.serial, out_ch.serial);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any handshake on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("easter_sunday_serial_unit_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                       pick;
    int                       near;
    logic signed [YEAR_W-1:0] yr;

    in_ch.valid  = 1'b0;
    in_ch.year   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;

    // Directed part. Known dates under the reset reference date (Easter 2000
    // on April 23, Easter 2024 on March 31), both range edges and the 16-bit
    // extremes, earliest and latest possible Easter, then the odd reference
    // dates: month zero and above twelve, day zero and past the month end,
    // year zero and above 9999 (serial wraps), and a write to the spare index.
    plan = '{
      '{1'b0, REG_NULL_YEAR, '0, 16'sd2000, 1'b1, '{1'b1, MON_APRIL, 5'd23, 23'sd36639}},
      '{1'b0, REG_NULL_YEAR, '0, 16'sd2024, 1'b1, '{1'b1, MON_MARCH, 5'd31, 23'sd45382}},
      '{1'b0, REG_NULL_YEAR, '0, 16'sd1582, 1'b1, NO_EASTER},
      '{1'b0, REG_NULL_YEAR, '0, 16'sd1583, 1'b0, NO_EASTER},
      '{1'b0, REG_NULL_YEAR, '0, 16'sd9956, 1'b0, NO_EASTER},
      '{1'b0, REG_NULL_YEAR, '0, 16'sd9957, 1'b1, NO_EASTER},
      '{1'b0, REG_NULL_YEAR, '0, -16'sd32768, 1'b1, NO_EASTER},
      '{1'b0, REG_NULL_YEAR, '0, 16'sd32767, 1'b1, NO_EASTER},
      '{1'b0, REG_NULL_YEAR, '0, 16'sd0, 1'b1, NO_EASTER},
      '{1'b0, REG_NULL_YEAR, '0, -16'sd1, 1'b1, NO_EASTER},
      '{1'b0, REG_NULL_YEAR, '0, 16'sd1818, 1'b0, NO_EASTER},
      '{1'b0, REG_NULL_YEAR, '0, 16'sd1943, 1'b0, NO_EASTER},
      '{1'b0, REG_NULL_YEAR, '0, 16'sd1899, 1'b0, NO_EASTER},
      '{1'b1, REG_NULL_MONTH, 14'h0000, '0, 1'b0, NO_EASTER},
      '{1'b0, REG_NULL_YEAR, '0, 16'sd2000, 1'b0, NO_EASTER},
      '{1'b1, REG_NULL_MONTH, 14'h3FFF, '0, 1'b0, NO_EASTER},
      '{1'b1, REG_NULL_DAY, 14'h3FE0, '0, 1'b0, NO_EASTER},
      '{1'b0, REG_NULL_YEAR, '0, 16'sd2000, 1'b0, NO_EASTER},
      '{1'b1, REG_NULL_YEAR, 14'd0, '0, 1'b0, NO_EASTER},
      '{1'b1, REG_NULL_MONTH, 14'd2, '0, 1'b0, NO_EASTER},
      '{1'b1, REG_NULL_DAY, 14'd31, '0, 1'b0, NO_EASTER},
      '{1'b0, REG_NULL_YEAR, '0, 16'sd1583, 1'b0, NO_EASTER},
      '{1'b1, REG_NULL_YEAR, 14'h3FFF, '0, 1'b0, NO_EASTER},
      '{1'b0, REG_NULL_YEAR, '0, 16'sd1583, 1'b0, NO_EASTER},
      '{1'b1, REG_UNUSED, 14'h1555, '0, 1'b0, NO_EASTER},
      '{1'b0, REG_NULL_YEAR, '0, 16'sd2000, 1'b0, NO_EASTER}
    };

    // Hold reset low, then release it at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_year(plan[i].year, plan[i].typed, plan[i].want);
      end
    end

    // Random part: six segments, each under its own reference date. The
    // first two idle the sender less than the receiver, the next two the
    // other way round, the last two run at full rate.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      src_idle_pct = (seg < 2) ? 29 : (seg < 4) ? 47 : 0;
      snk_idle_pct = (seg < 2) ? 47 : (seg < 4) ? 29 : 0;
      case (seg)
        0: set_epoch(14'd1, 14'd1, 14'd1);
        1: set_epoch(14'd9999, 14'd12, 14'd31);
        2: set_epoch(CFG_DATA_W'($urandom_range(9999, 1)),
                     CFG_DATA_W'($urandom_range(12, 1)),
                     CFG_DATA_W'($urandom_range(28, 1)));
        3: set_epoch(14'h3FFF, 14'd15, 14'd31);
        4: set_epoch(14'd0, 14'd0, 14'd0);
        default: begin
          set_epoch(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
          write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        end
      endcase
      repeat (ITEMS_PER_SEGMENT) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // Mostly years that get through the computus.
          yr = YEAR_W'($urandom_range(int'(LAST_YEAR), int'(FIRST_YEAR)));
        end else if (pick < 80) begin
          // Hug the range edges from both sides.
          near = ($urandom_range(1) ? int'(FIRST_YEAR) : int'(LAST_YEAR))
               + $urandom_range(6) - 3;
          yr = YEAR_W'(near);
        end else begin
          // Anything the 16-bit field can hold.
          yr = YEAR_W'($urandom);
        end
        send_year(yr, 1'b0, NO_EASTER);
      end
    end

    // Drain, then give the pipeline time to show any stray result.
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (pending_easters.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("easter_sunday_serial_unit_test: PASS");
    end else begin
      $display("easter_sunday_serial_unit_test: FAIL");
    end
    $finish;
  end

endmodule
